// ===== sv/grid_ray_caster_column_top_macros.svh =====
// Assertion helpers shared by the caster modules; both use clk and arst_n.
`ifndef GRID_RAY_CASTER_COLUMN_TOP_MACROS_SVH
`define GRID_RAY_CASTER_COLUMN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GRC_ASSERT_IMPL(lbl, ante, cons, msg)
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/grc_pkg.sv =====
package grc_pkg;

	localparam int MAP_SIDE_DEF = 32;
	localparam int MAX_BANDS    = 62;

	localparam int POS_W  = 16;
	localparam int VEC_W  = 16;
	localparam int CAM_W  = 28;
	localparam int RAY_W  = 30;
	localparam int DIST_W = 17;
	localparam int WH_W   = 25;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;
	localparam int DVD_W  = 48;
	localparam int DVS_W  = RAY_W + 3;
	localparam int ROW_W  = 16;
	localparam int TEX_W  = 9;
	localparam int CNT_W  = 6;

	localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd1280;
	localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd720;
	localparam logic [7:0]  CAMERA_HEIGHT_RST = 8'd115;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CAMERA_HEIGHT = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST  = 1'b1;

	localparam logic [1:0] KIND_BAND = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_ESC  = 2'd2;

	localparam logic [DIST_W-1:0] CELL_ONE = DIST_W'(2048);
	localparam logic [WH_W-1:0]   WH_CAP   = WH_W'(1 << 24);
	localparam int                CAMX_ONE = 16384;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [ROW_W-1:0] ground_row;
		logic signed [ROW_W-1:0] ceiling_row;
		logic                    checker_res;
		logic [TEX_W-1:0]        tex_u;
		logic [TEX_W-1:0]        tex_v;
		logic                    shaded;
		logic                    last;
	} res_t;

	function automatic logic signed [ROW_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
		if (v > PROD_W'(32767))
			return 16'sd32767;
		if (v < -PROD_W'(32768))
			return -16'sd32768;
		return ROW_W'(v);
	endfunction

endpackage

// ===== sv/grc_req_if.sv =====
interface grc_req_if;
	import grc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [4:0]              tile_x;
	logic [4:0]              tile_y;
	logic [3:0]              tile_code;
	logic [10:0]             column;
	logic [POS_W-1:0]        pos_x;
	logic [POS_W-1:0]        pos_y;
	logic signed [VEC_W-1:0] dir_x;
	logic signed [VEC_W-1:0] dir_y;
	logic signed [VEC_W-1:0] plane_x;
	logic signed [VEC_W-1:0] plane_y;

	modport source (output valid, func, tile_x, tile_y, tile_code, column, pos_x, pos_y,
		dir_x, dir_y, plane_x, plane_y, input ready);
	modport sink (input valid, func, tile_x, tile_y, tile_code, column, pos_x, pos_y,
		dir_x, dir_y, plane_x, plane_y, output ready);
endinterface

// ===== sv/grc_res_if.sv =====
interface grc_res_if;
	import grc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              kind;
	logic signed [ROW_W-1:0] ground_row;
	logic signed [ROW_W-1:0] ceiling_row;
	logic                    checker_res;
	logic [TEX_W-1:0]        tex_u;
	logic [TEX_W-1:0]        tex_v;
	logic                    shaded;
	logic                    last;

	modport source (output valid, kind, ground_row, ceiling_row, checker_res, tex_u, tex_v,
		shaded, last, input ready);
	modport sink (input valid, kind, ground_row, ceiling_row, checker_res, tex_u, tex_v,
		shaded, last, output ready);
endinterface

// ===== sv/grc_mul.sv =====
module grc_mul (
	input  logic                              clk,
	input  logic signed [grc_pkg::MUL_W-1:0]  a,
	input  logic signed [grc_pkg::MUL_W-1:0]  b,
	output logic signed [grc_pkg::PROD_W-1:0] p
);
	import grc_pkg::*;

	always_ff @(posedge clk) begin
		p <= PROD_W'(a) * PROD_W'(b);
	end
endmodule

// ===== sv/grc_div.sv =====
`include "grid_ray_caster_column_top_macros.svh"
module grc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  grc_pkg::div_req_t   req,
	output grc_pkg::div_rsp_t   rsp
);
	import grc_pkg::*;

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] diff;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one restoring step per cycle, quotient bits shift in from the right
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`GRC_ASSERT_NEXT(a_start_busy, req.start, busy_q, "divider did not start")
	`GRC_ASSERT_IMPL(a_done_idle, done_q, !busy_q, "divider done while busy")
	`GRC_ASSERT_IMPL(a_cnt_range, busy_q, cnt_q <= CNT_W'(DVD_W - 1), "divider count overrun")
endmodule

// ===== sv/grc_tile_mem.sv =====
module grc_tile_mem #(
	parameter  int MAP_SIDE = grc_pkg::MAP_SIDE_DEF,
	localparam int ADDR_W   = $clog2(MAP_SIDE * MAP_SIDE)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [3:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [3:0]        rdata
);
	logic [3:0] mem [MAP_SIDE*MAP_SIDE];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/grid_ray_caster_column_top.sv =====
// Tile-map column ray caster.
// req carries one request at a time: a tile write (func 0) or a column cast
// (func 1). A write is taken while the caster stays idle and gives no result. A cast
// walks the map cell by cell and sends one band result per cell entered on
// res, then a wall result or an escape result with last set.
// A cast first sets up the ray (camera x division), then for each cell crossed
// runs the shared divider for the wall height unless the distance is zero; a
// wall hit adds another divider pass for the texel. All products go through
// one registered 32x32 multiplier; req is ready only while no cast is in progress.
// res has a one-entry output register: a stalled receiver holds the result
// there and the caster waits before the next one; the next request is taken
// while the last result of a column still waits.
// Reset returns the registers to 1280, 720 and 115 and empties the output.
// The tile store is not cleared; write every tile before casting over it.
// cfg_we writes register cfg_index (0 width, 1 height, 2 eye height).
`include "grid_ray_caster_column_top_macros.svh"
module grid_ray_caster_column_top #(
	parameter int MAP_SIDE = grc_pkg::MAP_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	grc_req_if.sink     req,
	grc_res_if.source   res
);
	import grc_pkg::*;

	localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
	localparam int CRD_W  = $clog2(MAP_SIDE) + 2;

	typedef enum logic [21:0] {
		S_IDLE   = 22'h000001,
		S_CAMDIV = 22'h000002,
		S_RX     = 22'h000004,
		S_RY     = 22'h000008,
		S_INIT   = 22'h000010,
		S_START  = 22'h000020,
		S_CMP1   = 22'h000040,
		S_CMP2   = 22'h000080,
		S_CMP3   = 22'h000100,
		S_BOUND  = 22'h000200,
		S_WHMUL  = 22'h000400,
		S_WHDIV  = 22'h000800,
		S_G1     = 22'h001000,
		S_G2     = 22'h002000,
		S_G3     = 22'h004000,
		S_BAND   = 22'h008000,
		S_TEX1   = 22'h010000,
		S_TEX2   = 22'h020000,
		S_TEX3   = 22'h040000,
		S_TEXDIV = 22'h080000,
		S_FIN    = 22'h100000,
		S_ESC    = 22'h200000
	} state_t;

	state_t state_q, state_d;

	logic [10:0] sw_q, sh_q;
	logic [7:0]  camh_q;

	logic [POS_W-1:0]        px_q, py_q;
	logic signed [VEC_W-1:0] dirx_q, diry_q, planex_q, planey_q;
	logic signed [CAM_W-1:0] cam_q;
	logic signed [RAY_W-1:0] rx_q, ry_q;
	logic [RAY_W-1:0]        arx_q, ary_q, r_q;
	logic [DIST_W-1:0]       tx_q, ty_q, d_q;
	logic signed [CRD_W-1:0] cx_q, cy_q;
	logic                    chk_q, xside_q, neg_q;
	logic [5:0]              n_q;
	logic [WH_W-1:0]         wh_q;
	logic signed [ROW_W-1:0] g_q, c_q;
	logic [3:0]              code_q;
	logic [6:0]              tex_q;
	logic signed [PROD_W-1:0] acc_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              accept, tile_we, outside, slot_free, emit, emit_go, mirror;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [3:0]        rd_code;
	logic [10:0]       w_eff;
	logic [2:0]        tex_t;
	logic [6:0]        tex_m;
	logic signed [PROD_W-1:0] h_half, gnum, cnum, ctr, tex_num, tex_mag;
	res_t res_q, emit_res;
	logic res_valid_q;

	assign accept  = req.valid && req.ready;
	assign tile_we = accept && (req.func == FUNC_WRITE) && (32'(req.tile_x) < MAP_SIDE)
		&& (32'(req.tile_y) < MAP_SIDE);
	assign wr_addr = ADDR_W'(32'(req.tile_y) * MAP_SIDE + 32'(req.tile_x));
	assign rd_addr = ADDR_W'(32'(unsigned'(cy_q)) * MAP_SIDE + 32'(unsigned'(cx_q)));
	assign w_eff   = (sw_q == 11'd0) ? 11'd1 : sw_q;
	assign outside = (32'(px_q[15:11]) >= MAP_SIDE) || (32'(py_q[15:11]) >= MAP_SIDE);

	assign h_half  = $signed(PROD_W'({sh_q, 7'b0}));
	assign gnum    = prod + h_half;
	assign cnum    = h_half - prod;
	// C division truncates toward zero
	assign ctr     = cnum[PROD_W-1] ? -((-cnum) >>> 8) : (cnum >>> 8);
	assign tex_num = acc_q + prod;
	assign tex_mag = tex_num[PROD_W-1] ? -tex_num : tex_num;
	assign tex_t   = 3'(code_q - 4'd1);
	assign mirror  = (xside_q && (rx_q[RAY_W-1] || rx_q == '0)) || (!xside_q && !ry_q[RAY_W-1]);
	assign tex_m   = mirror ? ~tex_q : tex_q;

	assign slot_free = !res_valid_q || res.ready;
	assign emit_go   = emit && slot_free;

	grc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
	grc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	grc_tile_mem #(.MAP_SIDE(MAP_SIDE)) u_tiles (
		.clk(clk), .we(tile_we), .waddr(wr_addr), .wdata(req.tile_code),
		.raddr(rd_addr), .rdata(rd_code));

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		emit_res = '0;
		mul_a    = '0;
		mul_b    = '0;
		div_req  = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && req.func == FUNC_CAST) begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'({req.column, 15'b0});
					div_req.divisor  = DVS_W'(w_eff);
					state_d          = S_CAMDIV;
				end
			end
			S_CAMDIV: if (div_rsp.done) state_d = S_RX;
			S_RX: begin
				mul_a   = MUL_W'(planex_q);
				mul_b   = MUL_W'(cam_q);
				state_d = S_RY;
			end
			S_RY: begin
				mul_a   = MUL_W'(planey_q);
				mul_b   = MUL_W'(cam_q);
				state_d = S_INIT;
			end
			S_INIT: state_d = S_START;
			S_START: state_d = outside ? S_ESC : S_CMP1;
			S_CMP1: begin
				if (32'(n_q) >= MAX_BANDS) begin
					state_d = S_ESC;
				end else begin
					mul_a   = MUL_W'(tx_q);
					mul_b   = MUL_W'(ary_q);
					state_d = S_CMP2;
				end
			end
			S_CMP2: begin
				mul_a   = MUL_W'(ty_q);
				mul_b   = MUL_W'(arx_q);
				state_d = S_CMP3;
			end
			S_CMP3: state_d = S_BOUND;
			S_BOUND: begin
				if (cx_q < 0 || cx_q >= $signed(CRD_W'(MAP_SIDE)) || cy_q < 0
						|| cy_q >= $signed(CRD_W'(MAP_SIDE))) begin
					state_d = S_ESC;
				end else begin
					mul_a   = MUL_W'(sh_q);
					mul_b   = MUL_W'(r_q);
					state_d = S_WHMUL;
				end
			end
			S_WHMUL: begin
				if (d_q == '0) begin
					state_d = S_G1;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(prod);
					div_req.divisor  = DVS_W'({d_q, 3'b0});
					state_d          = S_WHDIV;
				end
			end
			S_WHDIV: if (div_rsp.done) state_d = S_G1;
			S_G1: begin
				mul_a   = MUL_W'(wh_q);
				mul_b   = MUL_W'(camh_q);
				state_d = S_G2;
			end
			S_G2: begin
				mul_a   = MUL_W'(wh_q);
				mul_b   = MUL_W'(9'd256 - 9'(camh_q));
				state_d = S_G3;
			end
			S_G3: state_d = S_BAND;
			S_BAND: begin
				emit                 = 1'b1;
				emit_res.kind        = KIND_BAND;
				emit_res.ground_row  = g_q;
				emit_res.ceiling_row = c_q;
				emit_res.checker_res = chk_q;
				if (slot_free)
					state_d = (code_q == 4'd0) ? S_CMP1 : S_TEX1;
			end
			S_TEX1: begin
				if (xside_q) begin
					mul_a   = MUL_W'(py_q);
					mul_b   = MUL_W'(arx_q);
					state_d = S_TEX2;
				end else if (ary_q != '0) begin
					mul_a   = MUL_W'(px_q);
					mul_b   = MUL_W'(ary_q);
					state_d = S_TEX2;
				end else begin
					state_d = S_FIN;
				end
			end
			S_TEX2: begin
				mul_a   = MUL_W'(d_q);
				mul_b   = xside_q ? MUL_W'(ry_q) : MUL_W'(rx_q);
				state_d = S_TEX3;
			end
			S_TEX3: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(tex_mag);
				div_req.divisor  = xside_q ? DVS_W'({arx_q[RAY_W-2:0], 4'b0})
					: DVS_W'({ary_q[RAY_W-2:0], 4'b0});
				state_d          = S_TEXDIV;
			end
			S_TEXDIV: if (div_rsp.done) state_d = S_FIN;
			S_FIN: begin
				emit                 = 1'b1;
				emit_res.kind        = KIND_WALL;
				emit_res.ground_row  = g_q;
				emit_res.ceiling_row = c_q;
				emit_res.tex_u       = {tex_t[1:0], tex_m};
				emit_res.tex_v       = {1'b0, tex_t[2], 7'b0};
				emit_res.shaded      = xside_q;
				emit_res.last        = 1'b1;
				if (slot_free) state_d = S_IDLE;
			end
			S_ESC: begin
				emit          = 1'b1;
				emit_res.kind = KIND_ESC;
				emit_res.last = 1'b1;
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			n_q         <= '0;
			sw_q        <= SCREEN_WIDTH_RST;
			sh_q        <= SCREEN_HEIGHT_RST;
			camh_q      <= CAMERA_HEIGHT_RST;
		end else begin
			state_q <= state_d;
			if (emit_go)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			if (state_q == S_START)
				n_q <= '0;
			else if (state_q == S_BAND && slot_free)
				n_q <= n_q + 6'd1;
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  sw_q   <= cfg_data;
					REG_SCREEN_HEIGHT: sh_q   <= cfg_data;
					REG_CAMERA_HEIGHT: camh_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go)
			res_q <= emit_res;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					px_q     <= req.pos_x;
					py_q     <= req.pos_y;
					dirx_q   <= req.dir_x;
					diry_q   <= req.dir_y;
					planex_q <= req.plane_x;
					planey_q <= req.plane_y;
				end
			end
			S_CAMDIV: if (div_rsp.done) cam_q <= CAM_W'(div_rsp.quotient) - CAM_W'(CAMX_ONE);
			S_RY: rx_q <= RAY_W'(prod >>> 14) + RAY_W'(dirx_q);
			S_INIT: ry_q <= RAY_W'(prod >>> 14) + RAY_W'(diry_q);
			S_START: begin
				arx_q <= rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
				ary_q <= ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);
				tx_q  <= rx_q[RAY_W-1] ? DIST_W'(px_q[10:0]) : CELL_ONE - DIST_W'(px_q[10:0]);
				ty_q  <= ry_q[RAY_W-1] ? DIST_W'(py_q[10:0]) : CELL_ONE - DIST_W'(py_q[10:0]);
				cx_q  <= CRD_W'(px_q[15:11]);
				cy_q  <= CRD_W'(py_q[15:11]);
				chk_q <= px_q[11] ^ py_q[11];
			end
			S_CMP2: acc_q <= prod;
			S_CMP3: begin
				// step along x only when its boundary is strictly nearer
				if (acc_q < prod) begin
					xside_q <= 1'b1;
					d_q     <= tx_q;
					r_q     <= arx_q;
					tx_q    <= tx_q + CELL_ONE;
					cx_q    <= rx_q[RAY_W-1] ? cx_q - CRD_W'(1) : cx_q + CRD_W'(1);
				end else begin
					xside_q <= 1'b0;
					d_q     <= ty_q;
					r_q     <= ary_q;
					ty_q    <= ty_q + CELL_ONE;
					cy_q    <= ry_q[RAY_W-1] ? cy_q - CRD_W'(1) : cy_q + CRD_W'(1);
				end
			end
			S_WHMUL: if (d_q == '0) wh_q <= WH_CAP;
			S_WHDIV: begin
				if (div_rsp.done)
					wh_q <= (div_rsp.quotient >= DVD_W'(WH_CAP)) ? WH_CAP
						: WH_W'(div_rsp.quotient);
			end
			S_G2: g_q <= sat16(gnum >>> 8);
			S_G3: begin
				c_q    <= sat16(ctr);
				code_q <= rd_code;
			end
			S_BAND: if (slot_free) chk_q <= ~chk_q;
			S_TEX1: if (!xside_q && ary_q == '0) tex_q <= px_q[10:4];
			S_TEX2: acc_q <= prod;
			S_TEX3: neg_q <= tex_num[PROD_W-1];
			S_TEXDIV: begin
				// floor of a negative quotient: -q, or -q-1 with a remainder
				if (div_rsp.done) begin
					if (!neg_q)
						tex_q <= div_rsp.quotient[6:0];
					else if (div_rsp.remainder != '0)
						tex_q <= ~div_rsp.quotient[6:0];
					else
						tex_q <= 7'(-div_rsp.quotient[6:0]);
				end
			end
			default: ;
		endcase
	end

	assign req.ready       = (state_q == S_IDLE);
	assign res.valid       = res_valid_q;
	assign res.kind        = res_q.kind;
	assign res.ground_row  = res_q.ground_row;
	assign res.ceiling_row = res_q.ceiling_row;
	assign res.checker_res = res_q.checker_res;
	assign res.tex_u       = res_q.tex_u;
	assign res.tex_v       = res_q.tex_v;
	assign res.shaded      = res_q.shaded;
	assign res.last        = res_q.last;

	`GRC_ASSERT_IMPL(a_div_free, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`GRC_ASSERT_IMPL(a_band_cap, state_q != S_IDLE, n_q <= 6'(MAX_BANDS), "band count overrun")
	`GRC_ASSERT_NEXT(a_emit_load, emit_go, res_valid_q, "result not loaded")
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import grc_pkg::*;

	localparam int  SIDE        = MAP_SIDE_DEF;
	localparam int  DRAIN_WAIT  = 200;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic        func;
		logic [4:0]  tile_x;
		logic [4:0]  tile_y;
		logic [3:0]  tile_code;
		logic [10:0] column;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
	} caster_req_t;

	typedef struct {
		caster_req_t req;
		int          n_typed;
		res_t        typed [2];
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [10:0] cfg_data;

	grc_req_if req_bus ();
	grc_res_if res_bus ();

	grid_ray_caster_column_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_bus.sink),
		.res       (res_bus.source)
	);

	// local copy of the block state
	logic [3:0]  map_codes [SIDE*SIDE];
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [7:0]  eye_q;

	res_t   pending_slices [$];
	int     errors;
	longint cycles;
	bit     quiet;
	bit     stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic res_t make_slice(input logic [1:0] kind, input longint g, input longint c,
		input bit chk, input longint u, input longint v, input bit sh, input bit lst);
		res_t r;
		r.kind        = kind;
		r.ground_row  = clip16(g);
		r.ceiling_row = clip16(c);
		r.checker_res = chk;
		r.tex_u       = u[8:0];
		r.tex_v       = v[8:0];
		r.shaded      = sh;
		r.last        = lst;
		return r;
	endfunction

	// walk one ray through the local map and queue every slice it yields
	task automatic cast_column(input caster_req_t it);
		longint w, cam, rx, ry, arx, ary, px, py, cx, cy, sxs, sys, tx, ty;
		longint d, r, wh, g, c, tex, t, hh, eye;
		bit chk, xside;
		int n;
		logic [3:0] code;
		w   = (width_q == 0) ? 1 : width_q;
		hh  = height_q;
		eye = eye_q;
		cam = (2 * longint'(it.column) * 16384) / w - 16384;
		rx  = longint'(it.dir_x) + floor_div(longint'(it.plane_x) * cam, 16384);
		ry  = longint'(it.dir_y) + floor_div(longint'(it.plane_y) * cam, 16384);
		arx = rx < 0 ? -rx : rx;
		ary = ry < 0 ? -ry : ry;
		px  = it.pos_x;
		py  = it.pos_y;
		cx  = px >>> 11;
		cy  = py >>> 11;
		if (cx >= SIDE || cy >= SIDE) begin
			pending_slices.push_back(make_slice(KIND_ESC, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		sxs = rx < 0 ? -1 : 1;
		sys = ry < 0 ? -1 : 1;
		tx  = rx < 0 ? (px & 2047) : 2048 - (px & 2047);
		ty  = ry < 0 ? (py & 2047) : 2048 - (py & 2047);
		chk = (cx ^ cy) & 1;
		n   = 0;
		forever begin
			if (n >= MAX_BANDS) begin
				pending_slices.push_back(make_slice(KIND_ESC, 0, 0, 0, 0, 0, 0, 1));
				return;
			end
			if (tx * ary < ty * arx) begin
				xside = 1; d = tx; r = arx; tx += 2048; cx += sxs;
			end else begin
				xside = 0; d = ty; r = ary; ty += 2048; cy += sys;
			end
			if (cx < 0 || cx >= SIDE || cy < 0 || cy >= SIDE) begin
				pending_slices.push_back(make_slice(KIND_ESC, 0, 0, 0, 0, 0, 0, 1));
				return;
			end
			if (d == 0)
				wh = 64'd16777216;
			else begin
				wh = (hh * r) / (8 * d);
				if (wh > 16777216)
					wh = 16777216;
			end
			g = (wh * eye + hh * 128) / 256;
			c = (hh * 128 - wh * (256 - eye)) / 256;
			pending_slices.push_back(make_slice(KIND_BAND, g, c, chk, 0, 0, 0, 0));
			chk = ~chk;
			n++;
			code = map_codes[cy * SIDE + cx];
			if (code != 0) begin
				if (xside)
					tex = floor_div(py * arx + d * ry, arx * 16);
				else if (ary != 0)
					tex = floor_div(px * ary + d * rx, ary * 16);
				else
					tex = px >>> 4;
				tex = tex & 127;
				// mirror on the far sides
				if ((xside && rx <= 0) || (!xside && ry >= 0))
					tex = 127 - tex;
				t = (code - 1) & 7;
				pending_slices.push_back(make_slice(KIND_WALL, g, c, 0,
					(t * 128) % 512 + tex, (t * 128 / 512) * 128, xside, 1));
				return;
			end
		end
	endtask

	task automatic send_request(input caster_req_t it, input int n_typed, input res_t typed [2]);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.func      <= it.func;
		req_bus.tile_x    <= it.tile_x;
		req_bus.tile_y    <= it.tile_y;
		req_bus.tile_code <= it.tile_code;
		req_bus.column    <= it.column;
		req_bus.pos_x     <= it.pos_x;
		req_bus.pos_y     <= it.pos_y;
		req_bus.dir_x     <= it.dir_x;
		req_bus.dir_y     <= it.dir_y;
		req_bus.plane_x   <= it.plane_x;
		req_bus.plane_y   <= it.plane_y;
		do @(posedge clk); while (!req_bus.ready);
		if (it.func == FUNC_WRITE)
			map_codes[int'(it.tile_y) * SIDE + int'(it.tile_x)] = it.tile_code;
		else if (n_typed > 0)
			for (int i = 0; i < n_typed; i++)
				pending_slices.push_back(typed[i]);
		else
			cast_column(it);
	endtask

	task automatic send(input caster_req_t it);
		res_t none [2];
		send_request(it, 0, none);
	endtask

	function automatic caster_req_t tile_write(input int x, input int y, input int code);
		caster_req_t it;
		it.func      = FUNC_WRITE;
		it.tile_x    = x;
		it.tile_y    = y;
		it.tile_code = code;
		it.column    = $urandom;
		it.pos_x     = $urandom;
		it.pos_y     = $urandom;
		it.dir_x     = $urandom;
		it.dir_y     = $urandom;
		it.plane_x   = $urandom;
		it.plane_y   = $urandom;
		return it;
	endfunction

	function automatic caster_req_t cast_req(input int col, input int px, input int py,
		input int dx, input int dy, input int plx, input int ply);
		caster_req_t it;
		it           = tile_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom);
		it.func      = FUNC_CAST;
		it.column    = col;
		it.pos_x     = px;
		it.pos_y     = py;
		it.dir_x     = dx;
		it.dir_y     = dy;
		it.plane_x   = plx;
		it.plane_y   = ply;
		return it;
	endfunction

	function automatic int rand_vec(input int mag);
		return int'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	function automatic caster_req_t random_cast();
		caster_req_t it;
		int sel;
		sel = $urandom_range(0, 9);
		it = cast_req($urandom_range(0, 2047), $urandom, $urandom,
			rand_vec(16384), rand_vec(16384), rand_vec(12000), rand_vec(12000));
		// noise: full-range vectors
		if (sel == 0) begin
			it.dir_x   = $urandom;
			it.dir_y   = $urandom;
			it.plane_x = $urandom;
			it.plane_y = $urandom;
		end else if (sel == 1) begin
			it.dir_y   = 0;
			it.plane_y = 0;
		end else if (sel == 2) begin
			it.dir_x   = 0;
			it.plane_x = 0;
		end
		return it;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_SCREEN_WIDTH:  width_q  = val;
			REG_SCREEN_HEIGHT: height_q = val;
			REG_CAMERA_HEIGHT: eye_q    = val[7:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		req_bus.valid <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// result side: random stalls, compare each accepted slice with the oldest expectation
	initial begin
		int stall;
		res_t exp_s;
		stall = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_bus.valid && res_bus.ready) begin
				if (pending_slices.size() == 0)
					report_mismatch("result with nothing expected");
				else begin
					exp_s = pending_slices.pop_front();
					if (res_bus.kind !== exp_s.kind)
						report_mismatch($sformatf("kind %0d exp %0d", res_bus.kind, exp_s.kind));
					if (res_bus.ground_row !== exp_s.ground_row)
						report_mismatch($sformatf("ground_row %0d exp %0d",
							res_bus.ground_row, exp_s.ground_row));
					if (res_bus.ceiling_row !== exp_s.ceiling_row)
						report_mismatch($sformatf("ceiling_row %0d exp %0d",
							res_bus.ceiling_row, exp_s.ceiling_row));
					if (res_bus.checker_res !== exp_s.checker_res)
						report_mismatch("checker_res");
					if (res_bus.tex_u !== exp_s.tex_u)
						report_mismatch($sformatf("tex_u %0d exp %0d", res_bus.tex_u, exp_s.tex_u));
					if (res_bus.tex_v !== exp_s.tex_v)
						report_mismatch($sformatf("tex_v %0d exp %0d", res_bus.tex_v, exp_s.tex_v));
					if (res_bus.shaded !== exp_s.shaded)
						report_mismatch("shaded");
					if (res_bus.last !== exp_s.last)
						report_mismatch("last");
				end
			end
			if (stall > 0) begin
				stall--;
				res_bus.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19);
				res_bus.ready <= 1'b0;
			end else
				res_bus.ready <= 1'b1;
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		res_t none [2];
		errors        = 0;
		cycles        = 0;
		quiet         = 0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SCREEN_WIDTH;
		cfg_data      = '0;
		req_bus.valid = 1'b0;
		req_bus.func  = FUNC_WRITE;
		{req_bus.tile_x, req_bus.tile_y, req_bus.tile_code, req_bus.column} = '0;
		{req_bus.pos_x, req_bus.pos_y, req_bus.dir_x, req_bus.dir_y} = '0;
		{req_bus.plane_x, req_bus.plane_y} = '0;
		width_q  = SCREEN_WIDTH_RST;
		height_q = SCREEN_HEIGHT_RST;
		eye_q    = CAMERA_HEIGHT_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole map first: walled border, sparse random interior
		for (int y = 0; y < SIDE; y++)
			for (int x = 0; x < SIDE; x++)
				if (x == 0 || y == 0 || x == SIDE - 1 || y == SIDE - 1)
					send(tile_write(x, y, 1));
				else
					send(tile_write(x, y, $urandom_range(0, 5) == 0 ? $urandom_range(1, 15) : 0));

		// directed table
		row.n_typed = 0;
		row.typed   = none;
		row.req = tile_write(1, 1, 0);                              rows.push_back(row);
		// from the middle of cell (1,1) straight at the west border wall
		row.req = cast_req(640, 3072, 3072, -16384, 0, 0, 0);
		row.n_typed  = 2;
		row.typed[0] = make_slice(KIND_BAND, 1006, -433, 0, 0, 0, 0, 0);
		row.typed[1] = make_slice(KIND_WALL, 1006, -433, 0, 63, 0, 1, 1);
		rows.push_back(row);
		row.n_typed = 0;
		row.req = tile_write(0, 5, 0);                              rows.push_back(row);
		row.req = tile_write(1, 5, 0);                              rows.push_back(row);
		row.req = cast_req(640, 3072, 11264, -16384, 0, 0, 0);      rows.push_back(row);
		row.req = tile_write(2, 3, 15);                             rows.push_back(row);
		row.req = tile_write(3, 2, 9);                              rows.push_back(row);
		row.req = tile_write(3, 3, 8);                              rows.push_back(row);
		row.req = tile_write(1, 3, 0);                              rows.push_back(row);
		row.req = cast_req(0, 3072, 7168, 16384, 0, 0, 16384);      rows.push_back(row);
		row.req = cast_req(2047, 3072, 7168, 16384, 0, 0, 16384);   rows.push_back(row);
		row.req = cast_req(1024, 3072, 3072, 0, 0, 0, 0);           rows.push_back(row);
		row.req = cast_req(1024, 3072, 3072, 0, -16384, 0, 0);      rows.push_back(row);
		row.req = cast_req(640, 0, 0, 16384, 16384, 0, 0);          rows.push_back(row);
		row.req = cast_req(640, 65535, 65535, -32768, -32768, 0, 0); rows.push_back(row);
		row.req = cast_req(2047, 4096, 4096, 32767, 32767, 32767, -32768);
		rows.push_back(row);
		row.req = cast_req(0, 2048, 6144, -32768, 32767, -32768, 32767);
		rows.push_back(row);
		row.req = cast_req(1280, 3072, 3072, -16384, 8, 0, 0);      rows.push_back(row);
		foreach (rows[i])
			send_request(rows[i].req, rows[i].n_typed, rows[i].typed);
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_SCREEN_WIDTH, 11'd2047);
					write_reg(REG_SCREEN_HEIGHT, 11'd2047);
					write_reg(REG_CAMERA_HEIGHT, 11'd255);
				end
				1: begin
					write_reg(REG_SCREEN_WIDTH, 11'd1);
					write_reg(REG_SCREEN_HEIGHT, 11'd1);
					write_reg(REG_CAMERA_HEIGHT, 11'd0);
				end
				2: begin
					// a zero width acts as one
					write_reg(REG_SCREEN_WIDTH, 11'd0);
					write_reg(REG_SCREEN_HEIGHT, 11'd0);
					write_reg(REG_CAMERA_HEIGHT, 11'($urandom_range(0, 255)));
				end
				default: begin
					write_reg(REG_SCREEN_WIDTH, 11'($urandom_range(1, 2047)));
					write_reg(REG_SCREEN_HEIGHT, 11'($urandom_range(1, 2047)));
					write_reg(REG_CAMERA_HEIGHT, 11'($urandom_range(0, 255)));
				end
			endcase
			if (ph == 4)
				quiet = 1;
			for (int k = 0; k < 30; k++) begin
				if ($urandom_range(0, 4) == 0)
					send(tile_write($urandom_range(1, 30), $urandom_range(1, 30),
						$urandom_range(0, 15)));
				send(random_cast());
			end
			drain();
		end

		stim_done = 1;
		if (errors == 0 && pending_slices.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
